>>> hdl/cfr_pkg.sv
// shared types, constants and the crc helper for the cobs/crc frame receiver
package cfr_pkg;

  // buffer sizes
  localparam int ENC_DEPTH  = 64;
  localparam int DEC_DEPTH  = 64;
  localparam int ENC_CNT_W  = $clog2(ENC_DEPTH + 1);
  localparam int DEC_CNT_W  = $clog2(DEC_DEPTH + 1);
  localparam int DEC_IDX_W  = $clog2(DEC_DEPTH);
  localparam int RAM_DEPTH  = 2 * DEC_DEPTH;
  localparam int RAM_ADDR_W = DEC_IDX_W + 1;
  localparam int FQ_DEPTH   = 2;
  localparam int FQ_PTR_W   = $clog2(FQ_DEPTH);
  localparam int FQ_CNT_W   = $clog2(FQ_DEPTH + 1);

  // frame layout: one version byte, two crc bytes
  localparam int MIN_FRAME = 3;

  // byte and crc constants
  localparam logic [7:0]  DELIM    = 8'h00;
  localparam logic [7:0]  CODE_FF  = 8'hFF;
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'h1021;

  // result kinds
  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_STATUS  = 1'b1;

  // frame status codes
  typedef enum logic [2:0] {
    STAT_OK       = 3'd0,
    STAT_DECODE   = 3'd1,
    STAT_CRC      = 3'd2,
    STAT_VERSION  = 3'd3,
    STAT_OVERFLOW = 3'd4
  } status_t;

  // frame descriptor handed from front to back
  typedef struct packed {
    status_t                status;
    logic [DEC_IDX_W-1:0]   pay_len;
    logic                   bank;
  } frame_desc_t;

  // crc-16/ccitt update with one byte, msb first
  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] data);
    logic [15:0] c;
    c = crc_in ^ {data, 8'h00};
    for (int b = 0; b < 8; b++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

>>> hdl/cobs_crc_frame_receiver_unit.sv
// top level of the cobs frame receiver with crc-16 check
// throughput: one link byte per cycle while full is low; results leave at one per cycle
// while pop is held, save when the sequencer starts on a payload frame; a failure status
// passes the descriptor queue and output register, a good frame's bytes a ram read too
// full rises while two finished frames wait in the descriptor queue (two ram banks)
// reset: control state cleared, protocol_version back to 1; the decoded ram is not cleared
module cobs_crc_frame_receiver_unit (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic [7:0] rx_byte,
  input  logic       cfg_wr_en,
  input  logic [7:0] cfg_wr_data,
  output logic       empty,
  input  logic       pop,
  output logic       kind,
  output logic [7:0] payload_byte,
  output logic       last,
  output logic [2:0] status
);

  logic [7:0]                     protocol_version;
  logic                           desc_push;
  cfr_pkg::frame_desc_t           desc;
  cfr_pkg::frame_desc_t           head;
  logic                           q_empty;
  logic                           q_pop;
  logic                           wr_en;
  logic [cfr_pkg::RAM_ADDR_W-1:0] wr_addr;
  logic [7:0]                     wr_data;
  logic                           rd_en;
  logic [cfr_pkg::RAM_ADDR_W-1:0] rd_addr;
  logic [7:0]                     rd_data;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      protocol_version <= 8'h01;
    end else if (cfg_wr_en) begin
      protocol_version <= cfg_wr_data;
    end
  end

  cfr_front u_front (
    .clk              (clk),
    .rst              (rst),
    .accept           (push && !full),
    .rx_byte          (rx_byte),
    .protocol_version (protocol_version),
    .desc_push        (desc_push),
    .desc             (desc),
    .wr_en            (wr_en),
    .wr_addr          (wr_addr),
    .wr_data          (wr_data)
  );

  cfr_fq u_fq (
    .clk       (clk),
    .rst       (rst),
    .push      (desc_push),
    .push_desc (desc),
    .pop       (q_pop),
    .head      (head),
    .empty     (q_empty),
    .full      (full)
  );

  cfr_ram #(
    .WIDTH (8),
    .DEPTH (cfr_pkg::RAM_DEPTH)
  ) u_dec_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  cfr_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (head),
    .q_empty      (q_empty),
    .q_pop        (q_pop),
    .rd_en        (rd_en),
    .rd_addr      (rd_addr),
    .rd_data      (rd_data),
    .pop          (pop),
    .empty        (empty),
    .kind         (kind),
    .payload_byte (payload_byte),
    .last         (last),
    .status       (status)
  );

endmodule

>>> hdl/cfr_ram.sv
// generic single write port ram with registered read
module cfr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> hdl/cfr_front.sv
// front end: streaming cobs decode, crc accumulation and frame classification
module cfr_front (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         accept,
  input  logic [7:0]                   rx_byte,
  input  logic [7:0]                   protocol_version,
  output logic                         desc_push,
  output cfr_pkg::frame_desc_t         desc,
  output logic                         wr_en,
  output logic [cfr_pkg::RAM_ADDR_W-1:0] wr_addr,
  output logic [7:0]                   wr_data
);

  logic [cfr_pkg::ENC_CNT_W-1:0] enc_cnt, enc_cnt_next;
  logic                          discarding, discarding_next;
  logic [7:0]                    left, left_next;
  logic                          code_ff, code_ff_next;
  logic [cfr_pkg::DEC_CNT_W-1:0] olen, olen_next;
  logic                          fail, fail_next;
  logic [15:0]                   crc, crc_next;
  logic [7:0]                    hist1, hist1_next;
  logic [7:0]                    hist2, hist2_next;
  logic [7:0]                    first_byte, first_byte_next;
  logic                          wbank, wbank_next;
  logic                          dec_valid;
  logic [7:0]                    dec_byte;
  cfr_pkg::status_t              frame_status;

  // classification of the finished frame
  always_comb begin
    priority if (fail || (left != 8'd0) ||
                 (olen < cfr_pkg::DEC_CNT_W'(cfr_pkg::MIN_FRAME))) begin
      frame_status = cfr_pkg::STAT_DECODE;
    end else if ({hist1, hist2} != crc) begin
      frame_status = cfr_pkg::STAT_CRC;
    end else if (first_byte != protocol_version) begin
      frame_status = cfr_pkg::STAT_VERSION;
    end else begin
      frame_status = cfr_pkg::STAT_OK;
    end
  end

  // per byte decode and descriptor generation
  always_comb begin
    enc_cnt_next    = enc_cnt;
    discarding_next = discarding;
    left_next       = left;
    code_ff_next    = code_ff;
    olen_next       = olen;
    fail_next       = fail;
    crc_next        = crc;
    hist1_next      = hist1;
    hist2_next      = hist2;
    first_byte_next = first_byte;
    wbank_next      = wbank;
    dec_valid       = 1'b0;
    dec_byte        = rx_byte;
    desc_push       = 1'b0;
    desc.status     = frame_status;
    desc.pay_len    = cfr_pkg::DEC_IDX_W'(olen - cfr_pkg::DEC_CNT_W'(cfr_pkg::MIN_FRAME));
    desc.bank       = wbank;
    wr_en           = 1'b0;
    wr_addr         = {wbank, olen[cfr_pkg::DEC_IDX_W-1:0]};

    if (accept) begin
      if (rx_byte != cfr_pkg::DELIM) begin
        if (discarding) begin
          // bytes after an overflow are dropped
        end else if (enc_cnt < cfr_pkg::ENC_CNT_W'(cfr_pkg::ENC_DEPTH)) begin
          enc_cnt_next = enc_cnt + 1'b1;
          if (enc_cnt == '0) begin
            // first code byte of a frame
            left_next    = rx_byte - 8'd1;
            code_ff_next = (rx_byte == cfr_pkg::CODE_FF);
            olen_next    = '0;
            fail_next    = 1'b0;
            crc_next     = cfr_pkg::CRC_INIT;
          end else if (left != 8'd0) begin
            dec_valid = 1'b1;
            left_next = left - 8'd1;
          end else begin
            // new group: implied zero unless the previous code was a full block
            dec_valid    = !code_ff;
            dec_byte     = cfr_pkg::DELIM;
            left_next    = rx_byte - 8'd1;
            code_ff_next = (rx_byte == cfr_pkg::CODE_FF);
          end
        end else begin
          // buffer overflow
          enc_cnt_next    = '0;
          discarding_next = 1'b1;
          desc_push       = 1'b1;
          desc.status     = cfr_pkg::STAT_OVERFLOW;
          desc.pay_len    = '0;
        end
      end else begin
        if (discarding) begin
          discarding_next = 1'b0;
          enc_cnt_next    = '0;
        end else if (enc_cnt != '0) begin
          desc_push    = 1'b1;
          enc_cnt_next = '0;
        end
      end
    end

    // store a decoded byte and run the delayed crc
    if (dec_valid) begin
      if (olen >= cfr_pkg::DEC_CNT_W'(cfr_pkg::DEC_DEPTH)) begin
        fail_next = 1'b1;
      end else begin
        wr_en     = 1'b1;
        olen_next = olen + 1'b1;
        if (olen == '0) begin
          first_byte_next = dec_byte;
        end
        if (olen >= cfr_pkg::DEC_CNT_W'(2)) begin
          crc_next = cfr_pkg::crc_byte(crc, hist2);
        end
        hist2_next = hist1;
        hist1_next = dec_byte;
      end
    end

    if (desc_push) begin
      wbank_next = !wbank;
    end
  end

  assign wr_data = dec_byte;

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      enc_cnt    <= '0;
      discarding <= 1'b0;
      wbank      <= 1'b0;
    end else begin
      enc_cnt    <= enc_cnt_next;
      discarding <= discarding_next;
      wbank      <= wbank_next;
    end
    left       <= left_next;
    code_ff    <= code_ff_next;
    olen       <= olen_next;
    fail       <= fail_next;
    crc        <= crc_next;
    hist1      <= hist1_next;
    hist2      <= hist2_next;
    first_byte <= first_byte_next;
  end

endmodule

>>> hdl/cfr_fq.sv
// short descriptor queue between front and back
module cfr_fq (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  cfr_pkg::frame_desc_t push_desc,
  input  logic                 pop,
  output cfr_pkg::frame_desc_t head,
  output logic                 empty,
  output logic                 full
);

  cfr_pkg::frame_desc_t         entries [cfr_pkg::FQ_DEPTH];
  logic [cfr_pkg::FQ_PTR_W-1:0] wr_ptr;
  logic [cfr_pkg::FQ_PTR_W-1:0] rd_ptr;
  logic [cfr_pkg::FQ_CNT_W-1:0] count;
  logic                         do_push;
  logic                         do_pop;

  assign empty   = (count == '0);
  assign full    = (count == cfr_pkg::FQ_CNT_W'(cfr_pkg::FQ_DEPTH));
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = entries[rd_ptr];

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == cfr_pkg::FQ_PTR_W'(cfr_pkg::FQ_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == cfr_pkg::FQ_PTR_W'(cfr_pkg::FQ_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_desc;
    end
  end

endmodule

>>> hdl/cfr_back.sv
// back end: drains decoded payload from the ram and issues status results
module cfr_back (
  input  logic                           clk,
  input  logic                           rst,
  input  cfr_pkg::frame_desc_t           head,
  input  logic                           q_empty,
  output logic                           q_pop,
  output logic                           rd_en,
  output logic [cfr_pkg::RAM_ADDR_W-1:0] rd_addr,
  input  logic [7:0]                     rd_data,
  input  logic                           pop,
  output logic                           empty,
  output logic                           kind,
  output logic [7:0]                     payload_byte,
  output logic                           last,
  output logic [2:0]                     status
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_FETCH,
    S_CLOSE
  } state_t;

  state_t                       state;
  logic [cfr_pkg::DEC_IDX_W-1:0] idx;
  logic [cfr_pkg::DEC_IDX_W-1:0] remain;
  logic                         o_valid;
  logic                         o_load;
  logic                         out_free;
  logic                         head_simple;
  logic                         start_fetch;

  assign out_free    = !o_valid || pop;
  assign head_simple = (head.status != cfr_pkg::STAT_OK) || (head.pay_len == '0);
  assign start_fetch = (state == S_IDLE) && !q_empty && out_free && !head_simple;
  assign empty       = !o_valid;

  // output register takes a new result whenever the sequencer issues one
  assign o_load = out_free &&
                  (((state == S_IDLE) && !q_empty && head_simple) ||
                   (state == S_FETCH) || (state == S_CLOSE));

  // queue pop and ram read control
  always_comb begin
    q_pop   = ((state == S_IDLE) && !q_empty && out_free && head_simple) ||
              ((state == S_CLOSE) && out_free);
    rd_en   = start_fetch ||
              ((state == S_FETCH) && out_free && (remain != cfr_pkg::DEC_IDX_W'(1)));
    rd_addr = (state == S_IDLE) ? {head.bank, cfr_pkg::DEC_IDX_W'(1)}
                                : {head.bank, idx + 1'b1};
  end

  // sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      o_valid <= 1'b0;
    end else begin
      o_valid <= o_load || (o_valid && !pop);
      unique case (state)
        S_IDLE: begin
          if (!q_empty && out_free) begin
            if (head_simple) begin
              kind         <= cfr_pkg::KIND_STATUS;
              payload_byte <= 8'h00;
              last         <= 1'b1;
              status       <= head.status;
            end else begin
              idx    <= cfr_pkg::DEC_IDX_W'(1);
              remain <= head.pay_len;
              state  <= S_FETCH;
            end
          end
        end
        S_FETCH: begin
          if (out_free) begin
            kind         <= cfr_pkg::KIND_PAYLOAD;
            payload_byte <= rd_data;
            last         <= 1'b0;
            status       <= cfr_pkg::STAT_OK;
            if (remain == cfr_pkg::DEC_IDX_W'(1)) begin
              state <= S_CLOSE;
            end else begin
              idx    <= idx + 1'b1;
              remain <= remain - 1'b1;
            end
          end
        end
        S_CLOSE: begin
          if (out_free) begin
            kind         <= cfr_pkg::KIND_STATUS;
            payload_byte <= 8'h00;
            last         <= 1'b1;
            status       <= cfr_pkg::STAT_OK;
            state        <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

>>> sim/tb.sv
// self-checking testbench for the cobs/crc frame receiver unit
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT   = 50000;
  localparam int SETTLE_CYCLES = 16;

  // one result as it leaves the block
  typedef struct packed {
    logic             kind;
    logic [7:0]       payload_byte;
    logic             last;
    cfr_pkg::status_t status;
  } rx_result_t;

  logic       clk         = 1'b0;
  logic       rst         = 1'b1;
  logic       push        = 1'b0;
  logic [7:0] rx_byte     = 8'h00;
  logic       cfg_wr_en   = 1'b0;
  logic [7:0] cfg_wr_data = 8'h00;
  logic       pop         = 1'b0;
  logic       full;
  logic       empty;
  logic       kind;
  logic [7:0] payload_byte;
  logic       last;
  logic [2:0] status;

  // deframer model state
  logic [7:0] link_buf [cfr_pkg::ENC_DEPTH];
  logic [7:0] frame_buf [cfr_pkg::DEC_DEPTH];
  int         link_cnt         = 0;
  bit         skipping         = 1'b0;
  logic [7:0] expected_version = 8'h01;

  rx_result_t rx_results_q [$];
  rx_result_t head;
  logic [7:0] frame_q [$];
  logic [7:0] wire_q [$];

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int errors         = 0;
  int cycles         = 0;

  cobs_crc_frame_receiver_unit i_dut (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .rx_byte      (rx_byte),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .empty        (empty),
    .pop          (pop),
    .kind         (kind),
    .payload_byte (payload_byte),
    .last         (last),
    .status       (status)
  );

  // 20 ns clock
  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  // run-away guard
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb: FAIL");
      $finish;
    end
  end

  // crc-16/ccitt, one bit at a time through the shift register
  function automatic logic [15:0] crc_step(input logic [15:0] c, input logic [7:0] d);
    logic [15:0] r;
    logic        fb;
    r = c;
    for (int i = 7; i >= 0; i--) begin
      fb = r[15] ^ d[i];
      r  = {r[14:0], 1'b0} ^ (fb ? cfr_pkg::CRC_POLY : 16'h0000);
    end
    return r;
  endfunction

  // cobs decode of the buffered link bytes into frame_buf; 0 on any failure
  function automatic int unstuff(input int n);
    int pos;
    int olen;
    int code;
    bit bad;
    pos  = 0;
    olen = 0;
    bad  = 1'b0;
    while (pos < n && !bad) begin
      code = link_buf[pos];
      pos++;
      if (code == 0 || pos + code - 1 > n) begin
        bad = 1'b1;
      end else begin
        for (int k = 1; k < code && !bad; k++) begin
          if (olen >= cfr_pkg::DEC_DEPTH) begin
            bad = 1'b1;
          end else begin
            frame_buf[olen] = link_buf[pos];
            olen++;
            pos++;
          end
        end
        if (!bad && code != cfr_pkg::CODE_FF && pos < n) begin
          if (olen >= cfr_pkg::DEC_DEPTH) begin
            bad = 1'b1;
          end else begin
            frame_buf[olen] = cfr_pkg::DELIM;
            olen++;
          end
        end
      end
    end
    return bad ? 0 : olen;
  endfunction

  task automatic queue_status(input cfr_pkg::status_t s);
    rx_results_q.push_back('{cfr_pkg::KIND_STATUS, 8'h00, 1'b1, s});
  endtask

  // results caused by one accepted link byte
  task automatic deframe_byte(input logic [7:0] b);
    int          dlen;
    logic [15:0] crc_rx;
    logic [15:0] crc_calc;
    if (b != cfr_pkg::DELIM) begin
      if (!skipping) begin
        if (link_cnt < cfr_pkg::ENC_DEPTH) begin
          link_buf[link_cnt] = b;
          link_cnt++;
        end else begin
          link_cnt = 0;
          skipping = 1'b1;
          queue_status(cfr_pkg::STAT_OVERFLOW);
        end
      end
    end else if (skipping) begin
      skipping = 1'b0;
      link_cnt = 0;
    end else if (link_cnt != 0) begin
      dlen     = unstuff(link_cnt);
      link_cnt = 0;
      if (dlen < cfr_pkg::MIN_FRAME) begin
        queue_status(cfr_pkg::STAT_DECODE);
      end else begin
        dlen     = dlen - 2;
        crc_rx   = {frame_buf[dlen + 1], frame_buf[dlen]};
        crc_calc = cfr_pkg::CRC_INIT;
        for (int i = 0; i < dlen; i++) crc_calc = crc_step(crc_calc, frame_buf[i]);
        if (crc_rx != crc_calc) begin
          queue_status(cfr_pkg::STAT_CRC);
        end else if (frame_buf[0] != expected_version) begin
          queue_status(cfr_pkg::STAT_VERSION);
        end else begin
          for (int i = 1; i < dlen; i++) begin
            rx_results_q.push_back('{cfr_pkg::KIND_PAYLOAD, frame_buf[i], 1'b0,
                                     cfr_pkg::STAT_OK});
          end
          queue_status(cfr_pkg::STAT_OK);
        end
      end
    end
  endtask

  // result side: random stalls, driven on the falling edge
  always @(negedge clk) begin
    pop <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // compare each result transfer with the oldest prediction
  always @(posedge clk) begin
    if (!rst && pop && !empty) begin
      if (rx_results_q.size() == 0) begin
        $error("unexpected result: kind %0d payload_byte %0h last %0d status %0d",
               kind, payload_byte, last, status);
        errors++;
      end else begin
        head = rx_results_q.pop_front();
        if (kind !== head.kind) begin
          $error("kind: expected %0d, got %0d", head.kind, kind);
          errors++;
        end
        if (payload_byte !== head.payload_byte) begin
          $error("payload_byte: expected %0h, got %0h", head.payload_byte, payload_byte);
          errors++;
        end
        if (last !== head.last) begin
          $error("last: expected %0d, got %0d", head.last, last);
          errors++;
        end
        if (status !== head.status) begin
          $error("status: expected %0d, got %0d", head.status, status);
          errors++;
        end
      end
    end
  end

  // one link byte transfer; each cycle in front of it idles at send_idle_pct
  task automatic push_link_byte(input logic [7:0] b);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      push = 1'b0;
      @(negedge clk);
    end
    push    = 1'b1;
    rx_byte = b;
    @(posedge clk);
    while (full) @(posedge clk);
    deframe_byte(b);
  endtask

  // stop sending and let every predicted result drain
  task automatic settle();
    @(negedge clk);
    push = 1'b0;
    while (rx_results_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_idling(input int send_pct, input int recv_pct);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
  endtask

  task automatic write_version(input logic [7:0] v);
    @(negedge clk);
    cfg_wr_en   = 1'b1;
    cfg_wr_data = v;
    @(negedge clk);
    cfg_wr_en        = 1'b0;
    expected_version = v;
  endtask

  // append the little-endian crc of everything in frame_q
  task automatic add_crc();
    logic [15:0] c;
    c = cfr_pkg::CRC_INIT;
    foreach (frame_q[i]) c = crc_step(c, frame_q[i]);
    frame_q.push_back(c[7:0]);
    frame_q.push_back(c[15:8]);
  endtask

  // version byte, n random payload bytes (zeros common), crc
  task automatic build_frame(input logic [7:0] ver, input int n);
    frame_q = {};
    frame_q.push_back(ver);
    repeat (n) begin
      frame_q.push_back(($urandom_range(0, 3) == 0) ? cfr_pkg::DELIM
                                                     : 8'($urandom_range(1, 255)));
    end
    add_crc();
  endtask

  // cobs encode frame_q into wire_q
  task automatic cobs_pack();
    int         code_at;
    logic [7:0] code;
    wire_q  = {};
    code_at = 0;
    wire_q.push_back(8'h00);
    code = 8'd1;
    foreach (frame_q[i]) begin
      if (frame_q[i] == cfr_pkg::DELIM) begin
        wire_q[code_at] = code;
        code_at = wire_q.size();
        wire_q.push_back(8'h00);
        code = 8'd1;
      end else begin
        wire_q.push_back(frame_q[i]);
        code++;
        if (code == cfr_pkg::CODE_FF) begin
          wire_q[code_at] = code;
          code_at = wire_q.size();
          wire_q.push_back(8'h00);
          code = 8'd1;
        end
      end
    end
    wire_q[code_at] = code;
  endtask

  // wire_q followed by the delimiter
  task automatic send_wire();
    foreach (wire_q[i]) push_link_byte(wire_q[i]);
    push_link_byte(cfr_pkg::DELIM);
  endtask

  // directed: payload extremes and the bare minimum frame at the reset version
  task automatic test_reset_version();
    frame_q = {8'h01, 8'h00, 8'hFF, 8'h01, 8'h80, 8'h7F, 8'h00};
    add_crc();
    cobs_pack();
    send_wire();
    frame_q = {8'h01};
    add_crc();
    cobs_pack();
    send_wire();
    settle();
  endtask

  // lone delimiters give nothing
  task automatic test_empty_frames();
    repeat (2) push_link_byte(cfr_pkg::DELIM);
    settle();
  endtask

  // decoded frames of one and two bytes
  task automatic test_short_frames();
    wire_q = {8'h02, 8'h5A};
    send_wire();
    wire_q = {8'h03, 8'h11, 8'h22};
    send_wire();
    settle();
  endtask

  // code bytes that run past the buffered data
  task automatic test_decode_errors();
    wire_q = {8'h05, 8'h11, 8'h22};
    send_wire();
    wire_q = {8'hFF, 8'h01, 8'h02, 8'h03};
    send_wire();
    settle();
  endtask

  // a crc byte corrupted, then a data byte
  task automatic test_crc_mismatch();
    build_frame(expected_version, 2);
    frame_q[frame_q.size() - 1] ^= 8'h01;
    cobs_pack();
    send_wire();
    build_frame(expected_version, 2);
    frame_q[2] ^= 8'h80;
    cobs_pack();
    send_wire();
    settle();
  endtask

  // wrong version alone, then wrong version with a bad crc: crc wins
  task automatic test_check_order();
    build_frame(8'h02, 1);
    cobs_pack();
    send_wire();
    build_frame(8'h02, 1);
    frame_q[frame_q.size() - 2] ^= 8'h40;
    cobs_pack();
    send_wire();
    settle();
  endtask

  // register extremes
  task automatic test_version_extremes();
    write_version(8'h00);
    build_frame(8'h00, 1);
    cobs_pack();
    send_wire();
    settle();
    write_version(8'hFF);
    build_frame(8'hFF, 1);
    cobs_pack();
    send_wire();
    build_frame(8'h00, 1);
    cobs_pack();
    send_wire();
    settle();
  endtask

  // buffer overflow, then a discarded byte up to the next delimiter
  task automatic test_overflow();
    wire_q = {};
    repeat (cfr_pkg::ENC_DEPTH + 1) wire_q.push_back(8'($urandom_range(1, 255)));
    wire_q.push_back(8'h01);
    send_wire();
    settle();
  endtask

  // longest frame that fits the link buffer exactly
  task automatic test_longest_frame();
    frame_q = {expected_version};
    repeat (cfr_pkg::DEC_DEPTH - 4) frame_q.push_back(8'($urandom_range(1, 255)));
    add_crc();
    cobs_pack();
    send_wire();
    settle();
  endtask

  // test sequence
  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    // sender idle chance 15 percent, receiver stall chance 47 percent
    set_idling(15, 47);
    test_reset_version();
    test_empty_frames();
    test_short_frames();
    test_decode_errors();
    // the other way round
    set_idling(47, 15);
    test_crc_mismatch();
    test_check_order();
    test_version_extremes();
    // neither side idles
    set_idling(0, 0);
    test_overflow();
    test_longest_frame();
    if (errors == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
